// File: hw/rtl/smax_pkg.sv
`default_nettype none
package smax_pkg;

  localparam int unsigned ScoreW = 16;
  localparam int unsigned TermW  = 17;
  localparam int unsigned SumW   = 23;
  localparam int unsigned RecipW = 25;
  localparam int unsigned ProbW  = 16;
  localparam int unsigned TW     = 33;

  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [15:0] MostNeg  = 16'h8000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD,
    S_SUB,
    S_MUL,
    S_EXP,
    S_USE,
    S_DIV,
    S_PROD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic ld_d;
    logic ld_t;
    logic ld_term;
  } exp_ctrl_t;

  function automatic logic [16:0] pow2_lut(input logic [4:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/smax_if.sv
`default_nettype none
interface smax_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] score;
  logic               row_end;
  modport source(output valid, output score, output row_end, input ready);
  modport sink(input valid, input score, input row_end, output ready);
endinterface

interface smax_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] probability;
  logic        row_done;
  modport source(output valid, output probability, output row_done, input ready);
  modport sink(input valid, input probability, input row_done, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/smax_exp.sv
`default_nettype none
module smax_exp (
  input  wire logic                    clk_i,
  input  wire smax_pkg::exp_ctrl_t     ctrl_i,
  input  wire logic [15:0]             max_i,
  input  wire logic [15:0]             score_i,
  output logic      [16:0]             term_o
);
  import smax_pkg::*;

  logic [15:0] d_q;
  logic [TW-1:0] t_q;
  logic [TermW-1:0] term_q;
  logic [8:0] n;
  logic [3:0] h;
  logic [3:0] l;
  logic [16:0] p_hi;
  logic [16:0] p_lo;
  logic [11:0] diff;
  logic [15:0] corr;
  logic [16:0] v;
  logic [TermW-1:0] term_d;

  always_comb begin
    n      = t_q[32:24];
    h      = t_q[23:20];
    l      = t_q[19:16];
    p_hi   = pow2_lut({1'b0, h});
    p_lo   = pow2_lut(5'({1'b0, h} + 5'd1));
    diff   = 12'(p_hi - p_lo);
    corr   = 16'(({4'd0, diff} * {12'd0, l} + 16'd8) >> 4);
    v      = p_hi - {1'b0, corr};
    term_d = (n >= 9'd17) ? '0 : (v >> n[4:0]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_d) begin
      d_q <= max_i - score_i;
    end
    if (ctrl_i.ld_t) begin
      t_q <= TW'({17'd0, d_q} * {16'd0, Log2eQ16});
    end
    if (ctrl_i.ld_term) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;
endmodule
`default_nettype wire

// File: hw/rtl/smax_div.sv
`default_nettype none
module smax_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [22:0] divisor_i,
  output logic      [24:0] quot_o,
  output logic             done_o
);
  import smax_pkg::*;

  logic              busy_q;
  logic [5:0]        cnt_q;
  logic [SumW-1:0]   div_q;
  logic [SumW:0]     rem_q;
  logic [RecipW-1:0] quot_q;
  logic [SumW:0]     shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_q[SumW-1:0], (cnt_q == 6'd40)};
    fits    = shifted >= {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd40;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= (divisor_i == '0) ? SumW'(1) : divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? shifted - {1'b0, div_q} : shifted;
      quot_q <= {quot_q[RecipW-2:0], fits};
    end
  end

  assign quot_o = quot_q;
endmodule
`default_nettype wire

// File: hw/rtl/softmax_row_normalize_top.sv
// softmax over a row of signed Q8.8 scores, probabilities out as unsigned Q0.16
// in_i: one score per transfer, row_end marks the last score of a row; a row
// also ends by itself at its MAX_COLS-th score
// out_o: one probability per score of the row, in arrival order, row_done on
// the last one
// loading takes one cycle per score; in_i.ready is low from the end of a row
// until its last probability has been taken
// after the row ends, each score is reread from the row memory and run through
// the shared exp unit twice: once in the sum pass, then a restoring divide forms
// the reciprocal, then once more in the output pass (memory read, subtract,
// multiply, interpolate, scale)
// a stalled receiver holds the output register and stops the sequencer
// reset clears the sequencer, the fill count and the running max; the row
// memory is not cleared since only written entries are read
`default_nettype none
module softmax_row_normalize_top #(
  parameter int unsigned MAX_COLS = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  smax_in_if.sink    in_i,
  smax_out_if.source out_o
);
  import smax_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_COLS);
  localparam int unsigned CntW = $clog2(MAX_COLS + 1);

  state_e state_q, state_d;
  logic [ScoreW-1:0] mem [MAX_COLS];
  logic [ScoreW-1:0] rd_q;
  logic [ScoreW-1:0] max_q;
  logic [CntW-1:0]   fill_q;
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   idx_q;
  logic              pass_q;
  logic [SumW-1:0]   sum_q;
  logic [RecipW-1:0] recip_q;
  logic [41:0]       prod_q;
  logic [ProbW-1:0]  prob_q;
  logic              done_q;

  exp_ctrl_t   exp_ctrl;
  logic [16:0] term;
  logic        div_start;
  logic        div_done;
  logic [24:0] quot;
  logic        in_fire;
  logic        out_fire;
  logic        row_last;
  logic        idx_last;
  logic [17:0] rounded;
  logic [SumW-1:0] sum_next;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign row_last = in_i.row_end || (fill_q == CntW'(MAX_COLS - 1));
  assign idx_last = (CntW'(idx_q) + CntW'(1)) == cnt_q;
  assign rounded  = 18'((prod_q + 42'd8388608) >> 24);
  assign sum_next = sum_q + SumW'(term);

  smax_exp u_exp (
    .clk_i  (clk_i),
    .ctrl_i (exp_ctrl),
    .max_i  (max_q),
    .score_i(rd_q),
    .term_o (term)
  );

  smax_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .divisor_i(sum_next),
    .quot_o   (quot),
    .done_o   (div_done)
  );

  always_comb begin
    state_d   = state_q;
    exp_ctrl  = '0;
    div_start = 1'b0;
    unique case (state_q)
      S_LOAD: if (in_fire && row_last) state_d = S_RD;
      S_RD:   state_d = S_SUB;
      S_SUB: begin
        exp_ctrl.ld_d = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        exp_ctrl.ld_t = 1'b1;
        state_d = S_EXP;
      end
      S_EXP: begin
        exp_ctrl.ld_term = 1'b1;
        state_d = S_USE;
      end
      S_USE: begin
        if (pass_q) begin
          state_d = S_PROD;
        end else if (idx_last) begin
          state_d = S_DIV;
        end else begin
          state_d = S_RD;
        end
      end
      S_DIV: begin
        div_start = 1'b0;
        if (div_done) state_d = S_RD;
      end
      S_PROD: state_d = S_OUT;
      S_OUT: begin
        if (out_fire) state_d = idx_last ? S_LOAD : S_RD;
      end
      default: state_d = S_LOAD;
    endcase
    if (state_q == S_USE && !pass_q && idx_last) div_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      max_q   <= MostNeg;
      fill_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      pass_q  <= 1'b0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_LOAD: begin
          if (in_fire) begin
            if ($signed(in_i.score) > $signed(max_q)) max_q <= in_i.score;
            fill_q <= fill_q + CntW'(1);
            if (row_last) begin
              cnt_q  <= fill_q + CntW'(1);
              idx_q  <= '0;
              pass_q <= 1'b0;
              sum_q  <= '0;
            end
          end
        end
        S_USE: begin
          if (!pass_q) begin
            sum_q <= sum_next;
            if (!idx_last) idx_q <= idx_q + IdxW'(1);
          end
        end
        S_DIV: begin
          if (div_done) begin
            idx_q  <= '0;
            pass_q <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            if (idx_last) begin
              max_q  <= MostNeg;
              fill_q <= '0;
              sum_q  <= '0;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) mem[fill_q[IdxW-1:0]] <= in_i.score;
    if (state_q == S_RD) rd_q <= mem[idx_q];
    if (div_done) recip_q <= quot;
    if (state_q == S_USE && pass_q) prod_q <= {25'd0, term} * {17'd0, recip_q};
    if (state_q == S_PROD) begin
      prob_q <= (rounded > 18'd65535) ? 16'hFFFF : rounded[15:0];
      done_q <= idx_last;
    end
  end

  assign in_i.ready        = (state_q == S_LOAD);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.probability = prob_q;
  assign out_o.row_done    = done_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input and output active together");

  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.row_done) |=> (fill_q == '0 && max_q == MostNeg))
    else $error("row state not cleared after last transfer");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> (fill_q < CntW'(MAX_COLS)))
    else $error("fill count out of range");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside wait state");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROD) |=> (done_q == $past(idx_last)))
    else $error("row_done flag mismatch");

endmodule
`default_nettype wire
